// ===== rtl/assert_macros.svh =====
// Assertion macros used by the port-level checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, clocked on clk_i, off during reset.
`define FVNH_ASSERT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, clocked on clk_i, off during reset.
`define FVNH_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/fvnh_pkg.sv =====
// Types, constants and register codes of the fractal value-noise height core.
`timescale 1ns / 1ps
package fvnh_pkg;

  localparam int MAX_OCTAVES_DFLT     = 8;
  localparam int COORD_FRAC_BITS_DFLT = 16;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  localparam logic [CFG_IDX_W-1:0] REG_PERSISTENCE    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BASE_FREQUENCY = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT_SCALE   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_OCTAVE_COUNT   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SEED           = 3'd4;

  localparam logic [31:0] HASH_MUL_Y   = 32'd57;
  localparam int          HASH_SHIFT   = 13;
  localparam logic [31:0] HASH_MUL_SQ  = 32'd15731;
  localparam logic [31:0] HASH_ADD_SQ  = 32'd789221;
  localparam logic [31:0] HASH_ADD_OUT = 32'd1376312589;
  localparam logic [31:0] HASH_MASK    = 32'h7fff_ffff;
  localparam logic [31:0] HASH_ONE     = 32'h4000_0000;

  localparam int NOISE_FRAC = 30;
  localparam int AMP_FRAC   = 16;
  localparam int SCALE_FRAC = 16;
  localparam int OFF_W      = 17;
  localparam int NOISE_W    = 44;

  localparam logic signed [63:0] LIM_Q    = 64'sh3fff_ffff_ffff_ffff;
  localparam logic signed [63:0] LIM_EDGE = 64'shc000_0000_0000_0000;
  localparam logic signed [63:0] I32_MAX  = 64'sh0000_0000_7fff_ffff;
  localparam logic signed [63:0] I32_MIN  = 64'shffff_ffff_8000_0000;

  typedef struct packed {
    logic signed [31:0] x_coord;
    logic signed [31:0] y_coord;
  } in_t;

  typedef struct packed {
    logic signed [31:0] height;
    logic               saturated;
  } out_t;

  typedef struct packed {
    logic first;
    logic last;
    logic nul;
  } ctl_t;

endpackage

// ===== rtl/fvnh_hash.sv =====
// One lattice hash unit: 32-bit wrapping integer hash in three stages.
`timescale 1ns / 1ps
module fvnh_hash (
  input  logic               clk_i,
  input  logic               en_i,
  input  logic [31:0]        x_i,
  input  logic [31:0]        y_i,
  output logic signed [31:0] g_o
);
  import fvnh_pkg::*;

  logic [31:0] n0, na, n2_d, m_d, t_d;
  logic [31:0] na_q, n2_q, nb_q, m_q;
  logic signed [31:0] g_d, g_q;

  always_comb begin
    n0   = x_i + y_i * HASH_MUL_Y;
    na   = (n0 << HASH_SHIFT) ^ n0;
    n2_d = na * na;
    m_d  = n2_q * HASH_MUL_SQ + HASH_ADD_SQ;
    t_d  = (nb_q * m_q + HASH_ADD_OUT) & HASH_MASK;
    g_d  = $signed(HASH_ONE - t_d);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      na_q <= na;
      n2_q <= n2_d;
      nb_q <= na_q;
      m_q  <= m_d;
      g_q  <= g_d;
    end
  end

  assign g_o = g_q;

endmodule

// ===== rtl/fvnh_seq.sv =====
// Octave issue sequencer: expands each item into one token per octave, or one null token if the count is zero.
`timescale 1ns / 1ps
module fvnh_seq #(
  parameter int MAX_OCTAVES = fvnh_pkg::MAX_OCTAVES_DFLT,
  parameter int KW          = $clog2(MAX_OCTAVES + 1),
  parameter int AW          = 17 + 2 * (MAX_OCTAVES - 1)
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           en_i,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  fvnh_pkg::in_t  in_data_i,
  input  logic [KW-1:0]  cnt_i,
  input  logic [17:0]    pers_i,
  output logic           tok_valid_o,
  output fvnh_pkg::in_t  tok_data_o,
  output logic [KW-1:0]  tok_k_o,
  output logic [AW-1:0]  tok_amp_o,
  output fvnh_pkg::ctl_t tok_ctl_o
);
  import fvnh_pkg::*;

  localparam logic [AW-1:0] AMP_ONE = AW'(1) << AMP_FRAC;

  logic          busy_q, busy_d, tok_v_q, emit;
  logic [KW-1:0] k_q, cur_k;
  logic [AW-1:0] amp_q, cur_amp, amp_d, tok_amp_q;
  logic [AW+17:0] amp_prod;
  in_t           hold_q, cur, tok_q;
  logic [KW-1:0] tok_k_q;
  ctl_t          cur_ctl, tok_ctl_q;

  always_comb begin
    emit     = busy_q || in_valid_i;
    cur_k    = busy_q ? k_q : '0;
    cur_amp  = busy_q ? amp_q : AMP_ONE;
    cur      = busy_q ? hold_q : in_data_i;
    cur_ctl.first = !busy_q;
    cur_ctl.nul   = (cnt_i == '0);
    cur_ctl.last  = (cnt_i == '0) || (cur_k == KW'(cnt_i - 1'b1));
    busy_d   = emit && !cur_ctl.last;
    amp_prod = (AW + 18)'(cur_amp) * (AW + 18)'(pers_i);
    amp_d    = AW'(amp_prod >> AMP_FRAC);
  end

  assign in_ready_o = en_i && !busy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      tok_v_q <= 1'b0;
    end else if (en_i) begin
      busy_q  <= busy_d;
      tok_v_q <= emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      k_q       <= KW'(cur_k + 1'b1);
      amp_q     <= amp_d;
      hold_q    <= cur;
      tok_q     <= cur;
      tok_k_q   <= cur_k;
      tok_amp_q <= cur_amp;
      tok_ctl_q <= cur_ctl;
    end
  end

  assign tok_valid_o = tok_v_q;
  assign tok_data_o  = tok_q;
  assign tok_k_o     = tok_k_q;
  assign tok_amp_o   = tok_amp_q;
  assign tok_ctl_o   = tok_ctl_q;

endmodule

// ===== rtl/fvnh_octave.sv =====
// Eight-stage octave pipeline: lattice split, sixteen hashes, smoothing, blends.
`timescale 1ns / 1ps
module fvnh_octave #(
  parameter int MAX_OCTAVES     = fvnh_pkg::MAX_OCTAVES_DFLT,
  parameter int COORD_FRAC_BITS = fvnh_pkg::COORD_FRAC_BITS_DFLT,
  parameter int KW              = $clog2(MAX_OCTAVES + 1),
  parameter int AW              = 17 + 2 * (MAX_OCTAVES - 1)
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  en_i,
  input  logic                                  valid_i,
  input  fvnh_pkg::in_t                         data_i,
  input  logic [KW-1:0]                         k_i,
  input  logic [AW-1:0]                         amp_i,
  input  fvnh_pkg::ctl_t                        ctl_i,
  input  logic [23:0]                           freq_i,
  input  logic [fvnh_pkg::OFF_W-1:0]            off_i,
  output logic                                  valid_o,
  output logic signed [fvnh_pkg::NOISE_W-1:0]   noise_o,
  output logic [AW-1:0]                         amp_o,
  output fvnh_pkg::ctl_t                        ctl_o
);
  import fvnh_pkg::*;

  localparam int NSTG = 8;
  localparam int FB   = COORD_FRAC_BITS + 16;
  localparam int MW   = 56;
  localparam int SHW  = MW + MAX_OCTAVES - 1;
  localparam int WW   = SHW - FB;
  localparam int CW   = (WW > OFF_W) ? WW : OFF_W;
  localparam int SW   = 34;
  localparam int BW   = 38;

  function automatic logic [62:0] lattice(input logic [MW-1:0] m, input logic neg,
                                          input logic [KW-1:0] k,
                                          input logic [OFF_W-1:0] off);
    logic [SHW-1:0]     msh;
    logic [WW-1:0]      whole;
    logic [FB-1:0]      f;
    logic [31:0]        ip;
    logic [29:0]        f30;
    logic               fneg;
    logic               gt;
    logic signed [30:0] fa;
    msh   = SHW'(m) << k;
    whole = msh[SHW-1:FB];
    f     = msh[FB-1:0];
    gt    = CW'(off) > CW'(whole);
    fneg  = 1'b0;
    if (!neg) begin
      ip = 32'(off) + 32'(whole);
    end else begin
      ip = 32'(off) - 32'(whole);
      if (f != '0) begin
        if (gt) begin
          ip = ip - 32'd1;
          f  = FB'(~f + 1'b1);
        end else begin
          fneg = 1'b1;
        end
      end
    end
    f30 = 30'({f, 30'b0} >> FB);
    fa  = fneg ? -$signed({1'b0, f30}) : $signed({1'b0, f30});
    return {ip, fa};
  endfunction

  logic [NSTG-1:0] v_q;
  logic [AW-1:0]   amp_q [NSTG];
  ctl_t            ctl_q [NSTG];

  logic [31:0]        ym_mag, xm_mag;
  logic [MW-1:0]      ym_q, xm_q;
  logic               yn_q, xn_q;
  logic [KW-1:0]      k1_q;
  logic [62:0]        lat_y, lat_x;
  logic [31:0]        p_q, q_q;
  logic signed [30:0] fa2_q, fb2_q, fa3_q, fb3_q;
  logic signed [61:0] sqa, sqb, cua, cub;
  logic signed [31:0] a2a3_q, a2b3_q, a2a4_q, a2b4_q, a3a4_q, a3b4_q;
  logic signed [SW-1:0] sa_d, sb_d, sa5_q, sb5_q, sa6_q, sb6_q, sb7_q;
  logic [31:0]        hx [16];
  logic [31:0]        hy [16];
  logic signed [31:0] g  [16];
  logic signed [35:0] sum [4];
  logic signed [31:0] cr_q [4];
  logic signed [32:0] d0, d1;
  logic signed [66:0] p0, p1;
  logic signed [BW-1:0] b0_d, b1_d, b0_q, b1_q;
  logic signed [BW:0] d2;
  logic signed [BW+SW:0] p2;
  logic signed [NOISE_W-1:0] n_d, n_q;

  always_comb begin
    ym_mag = data_i.y_coord[31] ? 32'(-data_i.y_coord) : 32'(data_i.y_coord);
    xm_mag = data_i.x_coord[31] ? 32'(-data_i.x_coord) : 32'(data_i.x_coord);
    lat_y  = lattice(ym_q, yn_q, k1_q, off_i);
    lat_x  = lattice(xm_q, xn_q, k1_q, off_i);
    sqa    = fa2_q * fa2_q;
    sqb    = fb2_q * fb2_q;
    cua    = 62'(a2a3_q) * 62'(fa3_q);
    cub    = 62'(a2b3_q) * 62'(fb3_q);
    sa_d   = SW'(a2a4_q) * 3 - SW'(a3a4_q) * 2;
    sb_d   = SW'(a2b4_q) * 3 - SW'(a3b4_q) * 2;
    for (int c = 0; c < 4; c++) begin
      sum[c] = '0;
      for (int v = 0; v < 3; v++) begin
        for (int u = 0; u < 3; u++) begin
          sum[c] = sum[c] + (36'(g[((c / 2) + v) * 4 + (c % 2) + u])
                   <<< ((u == 1 ? 1 : 0) + (v == 1 ? 1 : 0)));
        end
      end
    end
    d0   = 33'(cr_q[1]) - 33'(cr_q[0]);
    d1   = 33'(cr_q[3]) - 33'(cr_q[2]);
    p0   = d0 * sa6_q;
    p1   = d1 * sa6_q;
    b0_d = BW'(cr_q[0]) + BW'(p0 >>> NOISE_FRAC);
    b1_d = BW'(cr_q[2]) + BW'(p1 >>> NOISE_FRAC);
    d2   = (BW + 1)'(b1_q) - (BW + 1)'(b0_q);
    p2   = d2 * sb7_q;
    n_d  = NOISE_W'(b0_q) + NOISE_W'(p2 >>> NOISE_FRAC);
  end

  for (genvar i = 0; i < 16; i++) begin : g_hash
    assign hx[i] = p_q + 32'(i % 4) - 32'd1;
    assign hy[i] = q_q + 32'(i / 4) - 32'd1;
    fvnh_hash u_hash (
      .clk_i (clk_i),
      .en_i  (en_i),
      .x_i   (hx[i]),
      .y_i   (hy[i]),
      .g_o   (g[i])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[NSTG-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      amp_q[0] <= amp_i;
      ctl_q[0] <= ctl_i;
      for (int s = 1; s < NSTG; s++) begin
        amp_q[s] <= amp_q[s-1];
        ctl_q[s] <= ctl_q[s-1];
      end
      ym_q   <= MW'(ym_mag) * MW'(freq_i);
      xm_q   <= MW'(xm_mag) * MW'(freq_i);
      yn_q   <= data_i.y_coord[31];
      xn_q   <= data_i.x_coord[31];
      k1_q   <= k_i;
      p_q    <= lat_y[62:31];
      fa2_q  <= $signed(lat_y[30:0]);
      q_q    <= lat_x[62:31];
      fb2_q  <= $signed(lat_x[30:0]);
      fa3_q  <= fa2_q;
      fb3_q  <= fb2_q;
      a2a3_q <= 32'(sqa >>> NOISE_FRAC);
      a2b3_q <= 32'(sqb >>> NOISE_FRAC);
      a2a4_q <= a2a3_q;
      a2b4_q <= a2b3_q;
      a3a4_q <= 32'(cua >>> NOISE_FRAC);
      a3b4_q <= 32'(cub >>> NOISE_FRAC);
      sa5_q  <= sa_d;
      sb5_q  <= sb_d;
      for (int c = 0; c < 4; c++) begin
        cr_q[c] <= 32'(sum[c] >>> 4);
      end
      sa6_q  <= sa5_q;
      sb6_q  <= sb5_q;
      b0_q   <= b0_d;
      b1_q   <= b1_d;
      sb7_q  <= sb6_q;
      n_q    <= n_d;
    end
  end

  assign valid_o = v_q[NSTG-1];
  assign noise_o = n_q;
  assign amp_o   = amp_q[NSTG-1];
  assign ctl_o   = ctl_q[NSTG-1];

endmodule

// ===== rtl/fractal_value_noise_height_core.sv =====
// Top level of the fractal value-noise height core.
//
// Input channel in_valid_i/in_ready_o carries one point (x_coord, y_coord,
// signed Q16.16); output channel out_valid_o/out_ready_i carries one height
// (signed Q16.16, saturated) with its saturated flag for every point.
// Configuration writes come over cfg_valid_i/cfg_ready_o with a register
// index and data; cfg_ready_o is always high. Write only while idle.
// Each point is split into max(1, N) octave tokens, N = octave_count clamped
// to MAX_OCTAVES; the octave issue stage emits one token a cycle while the
// output is not stalled, and takes no new point until the last token of the
// previous point has been issued. Octave tokens run through a 12-stage
// pipeline shared by all octaves (sixteen hash units, smoothing, two blends,
// weighting, summing, final scaling).
// Reset clears the configuration registers and empties the pipeline.
// When the receiver stalls, the whole pipeline holds in place and
// in_ready_o drops; nothing is lost or repeated.
`timescale 1ns / 1ps
module fractal_value_noise_height_core #(
  parameter int MAX_OCTAVES     = fvnh_pkg::MAX_OCTAVES_DFLT,
  parameter int COORD_FRAC_BITS = fvnh_pkg::COORD_FRAC_BITS_DFLT
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  fvnh_pkg::in_t                      in_data_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output fvnh_pkg::out_t                     out_data_o,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [fvnh_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [fvnh_pkg::CFG_DATA_W-1:0]    cfg_data_i
);
  import fvnh_pkg::*;

  localparam int KW = $clog2(MAX_OCTAVES + 1);
  localparam int AW = 17 + 2 * (MAX_OCTAVES - 1);
  localparam int PW = NOISE_W + AW + 1;
  localparam int XW = (PW > 66) ? PW : 66;
  localparam int NH = NOISE_W / 2;

  logic [17:0]        persistence_q;
  logic [23:0]        base_frequency_q;
  logic signed [23:0] height_scale_q;
  logic [3:0]         octave_count_q;
  logic [7:0]         seed_q;

  logic                  adv;
  logic [KW-1:0]         cnt;
  logic [OFF_W-1:0]      off;
  logic                  tok_v;
  in_t                   tok_data;
  logic [KW-1:0]         tok_k;
  logic [AW-1:0]         tok_amp, oct_amp;
  ctl_t                  tok_ctl, oct_ctl, term_ctl_q;
  logic                  oct_v;
  logic signed [NOISE_W-1:0] oct_n;

  logic signed [NOISE_W-NH+AW:0] tp_hi;
  logic signed [NH+AW+1:0]       tp_lo;
  logic signed [XW-1:0]  tprod, tfl;
  logic signed [62:0]    term_d, term_q;
  logic                  term_v_q;
  logic signed [63:0]    acc_sum, acc_base;
  logic signed [62:0]    acc_d, acc_q;
  logic                  done_q;
  logic signed [54:0]    prod_hi_q;
  logic signed [56:0]    prod_lo_q;
  logic signed [86:0]    prod;
  logic                  prod_v_q;
  logic signed [56:0]    hfl;
  out_t                  out_d, out_q;
  logic                  out_v_q;

  assign adv         = !out_v_q || out_ready_i;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      persistence_q    <= '0;
      base_frequency_q <= '0;
      height_scale_q   <= '0;
      octave_count_q   <= '0;
      seed_q           <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_PERSISTENCE:    persistence_q    <= cfg_data_i[17:0];
        REG_BASE_FREQUENCY: base_frequency_q <= cfg_data_i;
        REG_HEIGHT_SCALE:   height_scale_q   <= $signed(cfg_data_i);
        REG_OCTAVE_COUNT:   octave_count_q   <= cfg_data_i[3:0];
        REG_SEED:           seed_q           <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cnt = (32'(octave_count_q) > 32'(MAX_OCTAVES)) ? KW'(MAX_OCTAVES)
                                                    : KW'(octave_count_q);
    off = OFF_W'(2) + OFF_W'(seed_q) * OFF_W'(seed_q);
  end

  fvnh_seq #(
    .MAX_OCTAVES (MAX_OCTAVES),
    .KW          (KW),
    .AW          (AW)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (adv),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .cnt_i       (cnt),
    .pers_i      (persistence_q),
    .tok_valid_o (tok_v),
    .tok_data_o  (tok_data),
    .tok_k_o     (tok_k),
    .tok_amp_o   (tok_amp),
    .tok_ctl_o   (tok_ctl)
  );

  fvnh_octave #(
    .MAX_OCTAVES     (MAX_OCTAVES),
    .COORD_FRAC_BITS (COORD_FRAC_BITS),
    .KW              (KW),
    .AW              (AW)
  ) u_octave (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (tok_v),
    .data_i  (tok_data),
    .k_i     (tok_k),
    .amp_i   (tok_amp),
    .ctl_i   (tok_ctl),
    .freq_i  (base_frequency_q),
    .off_i   (off),
    .valid_o (oct_v),
    .noise_o (oct_n),
    .amp_o   (oct_amp),
    .ctl_o   (oct_ctl)
  );

  always_comb begin
    tp_hi = $signed(oct_n[NOISE_W-1:NH]) * $signed({1'b0, oct_amp});
    tp_lo = $signed({1'b0, oct_n[NH-1:0]}) * $signed({1'b0, oct_amp});
    tprod = (XW'(tp_hi) <<< NH) + XW'(tp_lo);
    tfl   = tprod >>> AMP_FRAC;
    if (tfl > XW'(LIM_Q)) begin
      term_d = 63'(LIM_Q);
    end else if (tfl < XW'(LIM_EDGE) ||
                 (tfl == XW'(LIM_EDGE) && tprod[AMP_FRAC-1:0] == '0)) begin
      term_d = 63'(-LIM_Q);
    end else begin
      term_d = 63'(tfl);
    end
    acc_base = term_ctl_q.first ? 64'sd0 : 64'(acc_q);
    acc_sum  = acc_base + (term_ctl_q.nul ? 64'sd0 : 64'(term_q));
    if (acc_sum > LIM_Q) begin
      acc_d = 63'(LIM_Q);
    end else if (acc_sum < -LIM_Q) begin
      acc_d = 63'(-LIM_Q);
    end else begin
      acc_d = 63'(acc_sum);
    end
    prod = (87'(prod_hi_q) <<< 32) + 87'(prod_lo_q);
    hfl  = 57'(prod >>> NOISE_FRAC);
    out_d.saturated = 1'b0;
    if (hfl > 57'(I32_MAX)) begin
      out_d.height    = 32'sh7fff_ffff;
      out_d.saturated = 1'b1;
    end else if (hfl < 57'(I32_MIN)) begin
      out_d.height    = 32'sh8000_0000;
      out_d.saturated = 1'b1;
    end else begin
      out_d.height = 32'(hfl);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      term_v_q <= 1'b0;
      done_q   <= 1'b0;
      prod_v_q <= 1'b0;
      out_v_q  <= 1'b0;
    end else if (adv) begin
      term_v_q <= oct_v;
      done_q   <= term_v_q && term_ctl_q.last;
      prod_v_q <= done_q;
      out_v_q  <= prod_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      term_q     <= term_d;
      term_ctl_q <= oct_ctl;
      if (term_v_q) begin
        acc_q <= acc_d;
      end
      prod_hi_q <= $signed(acc_q[62:32]) * height_scale_q;
      prod_lo_q <= $signed({1'b0, acc_q[31:0]}) * height_scale_q;
      out_q     <= out_d;
    end
  end

  assign out_valid_o = out_v_q;
  assign out_data_o  = out_q;

endmodule

// ===== rtl/fvnh_checker.sv =====
// Port-level checker for the fractal value-noise height core, with its bind.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module fvnh_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           in_ready_o,
  input logic           out_valid_o,
  input logic           out_ready_i,
  input fvnh_pkg::out_t out_data_o
);
  import fvnh_pkg::*;

  `FVNH_ASSERT_NXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o, "out item dropped")
  `FVNH_ASSERT_NXT(a_out_stable, out_valid_o && !out_ready_i, $stable(out_data_o), "out item changed")
  `FVNH_ASSERT(a_stall_blocks_in, out_valid_o && !out_ready_i, !in_ready_o, "accept during stall")
  `FVNH_ASSERT(a_sat_clip, out_valid_o && out_data_o.saturated, out_data_o.height == 32'sh7fffffff || out_data_o.height == 32'sh80000000, "sat flag off range edge")

endmodule

bind fractal_value_noise_height_core fvnh_checker u_fvnh_checker (.*);
